// ===== rtl/core/fir_filter_adc_to_dac_macros.svh =====
// Assertion helpers shared by the filter modules.
`ifndef FIR_FILTER_ADC_TO_DAC_MACROS_SVH
`define FIR_FILTER_ADC_TO_DAC_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define FADC_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define FADC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/fadc_pkg.sv =====
package fadc_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int COEF_W     = 18;
    localparam int ACC_W      = 40;
    localparam int COEF_SHIFT = 21;
    localparam int Q_W        = ACC_W - COEF_SHIFT;
    localparam int TABLE_TAPS = 101;
    localparam int HALF_LEN   = 51;
    localparam logic [SAMPLE_W-1:0] DAC_MAX = 12'd4095;

    // Coefficients 0..50 scaled by 2^21; the upper half mirrors them.
    localparam logic signed [COEF_W-1:0] HALF_COEF [HALF_LEN] = '{
          18'sd4213,    18'sd1343,   -18'sd3704,   -18'sd3978,
          18'sd1658,    18'sd5925,    18'sd2040,   -18'sd5984,
         -18'sd6725,    18'sd2889,   18'sd10509,    18'sd3643,
        -18'sd10668,  -18'sd11894,    18'sd5047,   18'sd18073,
          18'sd6156,  -18'sd17691,  -18'sd19343,    18'sd8047,
         18'sd28251,    18'sd9436,  -18'sd26602,  -18'sd28546,
         18'sd11660,   18'sd40217,   18'sd13203,  -18'sd36606,
        -18'sd38650,   18'sd15541,   18'sd52788,   18'sd17075,
        -18'sd46663,  -18'sd48581,   18'sd19268,   18'sd64583,
         18'sd20619,  -18'sd55635,  -18'sd57202,   18'sd22412,
         18'sd74220,   18'sd23417,  -18'sd62453,  -18'sd63479,
         18'sd24591,   18'sd80527,   18'sd25127,  -18'sd66280,
        -18'sd66637,   18'sd25535,   18'sd82722
    };

    function automatic logic signed [COEF_W-1:0] tap_coef(input logic [8:0] k);
        logic [8:0] m;
        m = k;
        if (k >= 9'(TABLE_TAPS)) begin
            return '0;
        end
        if (k >= 9'(HALF_LEN)) begin
            m = 9'(TABLE_TAPS - 1) - k;
        end
        return HALF_COEF[m[5:0]];
    endfunction

    typedef struct packed {
        logic start;
        logic issue;
        logic finish;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic last_tap;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/core/fadc_ram.sv =====
module fadc_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 202
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/fadc_ctrl.sv =====
`include "fir_filter_adc_to_dac_macros.svh"

module fadc_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  fadc_pkg::status_t status,
    output fadc_pkg::cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_RUN    = 6'b000010,
        ST_DRAIN1 = 6'b000100,
        ST_DRAIN2 = 6'b001000,
        ST_FIN    = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                cmd.issue = 1'b1;
                if (status.last_tap) begin
                    state_next = ST_DRAIN1;
                end
            end
            // let the read and multiply stages empty into the accumulator
            ST_DRAIN1: state_next = ST_DRAIN2;
            ST_DRAIN2: state_next = ST_FIN;
            ST_FIN: begin
                cmd.finish = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register can take the beat
                if (status.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    `FADC_ASSERT_NEXT(a_last_tap_drains, aclk, aresetn, (state_reg == ST_RUN) && status.last_tap, state_reg == ST_DRAIN1, "tap sweep did not end on last tap")
    `FADC_ASSERT_NEXT(a_start_blocks_input, aclk, aresetn, cmd.start, (state_reg == ST_RUN) && !s_ready, "input still open after a start")

endmodule

// ===== rtl/core/fadc_datapath.sv =====
`include "fir_filter_adc_to_dac_macros.svh"

module fadc_datapath #(
    parameter int TAPS     = 101,
    parameter int CHANNELS = 2
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  fadc_pkg::cmd_t                     cmd,
    output fadc_pkg::status_t                  status,
    input  logic [fadc_pkg::SAMPLE_W-1:0]      s_sample,
    input  logic                               s_channel,
    input  logic                               cfg_we,
    input  logic [fadc_pkg::SAMPLE_W-1:0]      cfg_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [fadc_pkg::SAMPLE_W-1:0]      m_dac_code,
    output logic                               m_out_channel,
    output logic                               m_clipped
);

    localparam int TAP_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int FILL_W = $clog2(TAPS + 1);
    localparam int LSEL_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DEPTH  = CHANNELS * TAPS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW     = fadc_pkg::SAMPLE_W;
    localparam int QW     = fadc_pkg::Q_W;
    localparam int CW     = fadc_pkg::COEF_W;
    localparam int AW     = fadc_pkg::ACC_W;
    localparam int SH     = fadc_pkg::COEF_SHIFT;
    localparam int PW     = CW + SW + 1;

    // control state
    logic [FILL_W-1:0] fill_reg [CHANNELS];
    logic [TAP_W-1:0]  wptr_reg [CHANNELS];
    logic [TAP_W-1:0]  tap_reg;
    logic              v1_reg;
    logic              v2_reg;
    logic              m_valid_reg;
    logic [SW-1:0]     offset_reg;

    // item payload
    logic [LSEL_W-1:0]    line_reg;
    logic                 chan_reg;
    logic [TAP_W-1:0]     rd_ptr_reg;
    logic [FILL_W-1:0]    cur_fill_reg;
    logic signed [CW-1:0] coef1_reg;
    logic                 ok1_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [QW-1:0] q_reg;
    logic [SW-1:0]        m_dac_code_reg;
    logic                 m_out_channel_reg;
    logic                 m_clipped_reg;

    logic [LSEL_W-1:0]    s_line;
    logic [TAP_W-1:0]     wr_ptr;
    logic [TAP_W-1:0]     wptr_inc;
    logic [TAP_W-1:0]     rd_ptr_dec;
    logic [FILL_W-1:0]    fill_cur;
    logic [FILL_W-1:0]    fill_inc;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [SW-1:0]        ram_rdata;
    logic [SW-1:0]        tap_sample;
    logic                 round_up;
    logic signed [QW-1:0] q_trunc;
    logic signed [QW:0]   val_sum;
    logic                 clip_lo;
    logic                 clip_hi;
    logic [SW-1:0]        dac_next;

    // a channel without its own line falls back to line 0
    assign s_line   = (CHANNELS > 1) ? LSEL_W'(s_channel) : {LSEL_W{1'b0}};
    assign wr_ptr   = wptr_reg[s_line];
    assign fill_cur = fill_reg[s_line];
    assign fill_inc = (fill_cur == FILL_W'(TAPS)) ? fill_cur : fill_cur + 1'b1;
    assign wptr_inc = (wr_ptr == TAP_W'(TAPS - 1)) ? {TAP_W{1'b0}} : wr_ptr + 1'b1;
    assign rd_ptr_dec = (rd_ptr_reg == {TAP_W{1'b0}}) ? TAP_W'(TAPS - 1)
                                                      : rd_ptr_reg - 1'b1;

    assign ram_waddr = ADDR_W'(s_line * TAPS + wr_ptr);
    assign ram_raddr = ADDR_W'(line_reg * TAPS + rd_ptr_reg);

    fadc_ram #(
        .WIDTH(SW),
        .DEPTH(DEPTH)
    ) u_line_ram (
        .aclk (aclk),
        .we   (cmd.start),
        .waddr(ram_waddr),
        .wdata(s_sample),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // taps older than the line's fill count read as zero
    assign tap_sample = ok1_reg ? ram_rdata : {SW{1'b0}};

    // shift by 2^21, truncating toward zero
    assign round_up = acc_reg[AW-1] && (|acc_reg[SH-1:0]);
    assign q_trunc  = acc_reg[AW-1:SH] + {{(QW-1){1'b0}}, round_up};

    assign val_sum  = {q_reg[QW-1], q_reg} + {{(QW+1-SW){1'b0}}, offset_reg};
    assign clip_lo  = val_sum[QW];
    assign clip_hi  = !val_sum[QW] && (|val_sum[QW-1:SW]);
    assign dac_next = clip_lo ? {SW{1'b0}} : (clip_hi ? fadc_pkg::DAC_MAX : val_sum[SW-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '{default: '0};
            wptr_reg    <= '{default: '0};
            tap_reg     <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            offset_reg  <= '0;
        end else begin
            if (cfg_we) begin
                offset_reg <= cfg_data;
            end
            if (cmd.start) begin
                fill_reg[s_line] <= fill_inc;
                wptr_reg[s_line] <= wptr_inc;
                tap_reg          <= '0;
            end else if (cmd.issue) begin
                tap_reg <= tap_reg + 1'b1;
            end
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            if (cmd.load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            line_reg     <= s_line;
            chan_reg     <= s_channel;
            rd_ptr_reg   <= wr_ptr;
            cur_fill_reg <= fill_inc;
            acc_reg      <= '0;
        end else begin
            if (cmd.issue) begin
                rd_ptr_reg <= rd_ptr_dec;
            end
            if (v2_reg) begin
                acc_reg <= acc_reg + AW'(prod_reg);
            end
        end
        coef1_reg <= fadc_pkg::tap_coef(9'(tap_reg));
        ok1_reg   <= (FILL_W'(tap_reg) < cur_fill_reg);
        prod_reg  <= coef1_reg * $signed({1'b0, tap_sample});
        if (cmd.finish) begin
            q_reg <= q_trunc;
        end
        if (cmd.load) begin
            m_dac_code_reg    <= dac_next;
            m_out_channel_reg <= chan_reg;
            m_clipped_reg     <= clip_lo || clip_hi;
        end
    end

    assign status.last_tap = (tap_reg == TAP_W'(TAPS - 1));
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_dac_code    = m_dac_code_reg;
    assign m_out_channel = m_out_channel_reg;
    assign m_clipped     = m_clipped_reg;

    `FADC_ASSERT_IMPL(a_pipe_empty_at_finish, aclk, aresetn, cmd.finish, !v1_reg && !v2_reg && !cmd.issue, "accumulator read before products drained")
    `FADC_ASSERT_IMPL(a_load_no_overwrite, aclk, aresetn, cmd.load, !m_valid_reg || m_ready, "result loaded over a pending beat")

endmodule

// ===== rtl/core/fir_filter_adc_to_dac.sv =====
// Two-channel FIR filter, ADC codes in, saturated DAC codes out.
// After input accept, the controller steps RUN (tap sweep), DRAIN1, DRAIN2, FIN and DONE to output valid.
// A new input is accepted only back in IDLE, once the result is loaded into a free output register;
// the single multiply-accumulate walks one tap per cycle through the delay-line RAM read port.
// Reset: synchronous active-low aresetn empties both delay lines (fill counts) and
// clears the output offset (offset_reg) to 0; no clearing pass, input is ready right after reset.
module fir_filter_adc_to_dac #(
    parameter int TAPS     = 101,
    parameter int CHANNELS = 2
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [fadc_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                          s_channel,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [fadc_pkg::SAMPLE_W-1:0] m_dac_code,
    output logic                          m_out_channel,
    output logic                          m_clipped,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fadc_pkg::SAMPLE_W-1:0] cfg_data
);

    fadc_pkg::cmd_t    cmd;
    fadc_pkg::status_t status;

    assign cfg_ready = 1'b1;

    fadc_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .status (status),
        .cmd    (cmd)
    );

    fadc_datapath #(
        .TAPS    (TAPS),
        .CHANNELS(CHANNELS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .s_sample     (s_sample),
        .s_channel    (s_channel),
        .cfg_we       (cfg_valid),
        .cfg_data     (cfg_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_dac_code   (m_dac_code),
        .m_out_channel(m_out_channel),
        .m_clipped    (m_clipped)
    );

endmodule
